[src/assert_macros.svh]
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/bsc_pkg.sv]
// Package with the word types, register indexes and small helpers of the compensation core.
package bsc_pkg;

	// Input word: reading kind and raw sensor bits.
	typedef struct packed {
		logic        cmd;
		logic [23:0] raw_sample;
	} in_t;

	// Output word: result kind, compensated value and divide fault.
	typedef struct packed {
		logic               result_kind;
		logic signed [31:0] result_value;
		logic               divide_fault;
	} out_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_CALIB_A = 2'd0;
	localparam logic [1:0] REG_CALIB_B = 2'd1;
	localparam logic [1:0] REG_CALIB_C = 2'd2;
	localparam logic [1:0] REG_OSS     = 2'd3;

	// Reading kinds.
	localparam logic CMD_TEMP  = 1'b0;
	localparam logic CMD_PRESS = 1'b1;

	localparam logic [31:0] B6_OFFSET  = 32'd4000;
	localparam logic [31:0] B4_OFFSET  = 32'd32768;
	localparam logic [31:0] P_COEF_A   = 32'd3038;
	localparam logic [31:0] P_COEF_B   = 32'hFFFF_E343; // -7357
	localparam logic [31:0] P_COEF_C   = 32'd3791;
	localparam logic [1:0]  OSS_RESET  = 2'd3;

	// Sign-extend a 16-bit coefficient to 32 bits.
	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	// Arithmetic right shift of a 32-bit word.
	function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
		return 32'($signed(v) >>> s);
	endfunction

	// Pressure scaling constant 50000 >> oss.
	function automatic logic [31:0] scale_of(input logic [1:0] oss);
		logic [31:0] r;
		case (oss)
			2'd0: r = 32'd50000;
			2'd1: r = 32'd25000;
			2'd2: r = 32'd12500;
			default: r = 32'd6250;
		endcase
		return r;
	endfunction

endpackage

[src/baro_sensor_compensation_core.sv]
// Top level of the barometric sensor compensation core: sequencer, shared multiplier, divider.
// Each word in gives one word out. A reading is worked through from acceptance to the
// result by one shared 32x32 multiplier stepped by the sequencer plus the bit-serial
// divider; in_ready is low while a reading is in work. A finished result sits in the
// output register, and the next reading is taken while it waits. Temperature readings
// update the stored b5 that later pressure readings use (zero after reset). A zero
// divisor gives value 0 with divide_fault set. Configuration writes are always taken
// (cfg_ready is high) and must only be issued while the core is idle.
module baro_sensor_compensation_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  bsc_pkg::in_t    in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output bsc_pkg::out_t   out_data,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [63:0]     cfg_data
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_T0   = 5'd1;
	localparam logic [4:0] S_T1   = 5'd2;
	localparam logic [4:0] S_TDIV = 5'd3;
	localparam logic [4:0] S_TF   = 5'd4;
	localparam logic [4:0] S_TR   = 5'd5;
	localparam logic [4:0] S_P0   = 5'd6;
	localparam logic [4:0] S_P1   = 5'd7;
	localparam logic [4:0] S_P2   = 5'd8;
	localparam logic [4:0] S_P3   = 5'd9;
	localparam logic [4:0] S_P4   = 5'd10;
	localparam logic [4:0] S_P5   = 5'd11;
	localparam logic [4:0] S_P6   = 5'd12;
	localparam logic [4:0] S_P7   = 5'd13;
	localparam logic [4:0] S_PDIV = 5'd14;
	localparam logic [4:0] S_P8   = 5'd15;
	localparam logic [4:0] S_P9   = 5'd16;
	localparam logic [4:0] S_P10  = 5'd17;
	localparam logic [4:0] S_P11  = 5'd18;
	localparam logic [4:0] S_OUT  = 5'd19;

	logic [4:0]  state_q;
	logic [63:0] calib_a_q;
	logic [63:0] calib_b_q;
	logic [31:0] calib_c_q;
	logic [1:0]  oss_q;
	logic [31:0] last_b5_q;
	logic        cmd_q;
	logic [23:0] raw_q;
	logic [31:0] prod_q;
	logic [31:0] acc_q;
	logic [31:0] sq_q;
	logic [31:0] b6_q;
	logic [31:0] b3_q;
	logic [31:0] b4_q;
	logic [31:0] pv_q;
	logic        neg_q;
	logic        shl_q;
	logic [31:0] res_q;
	logic        fault_q;
	logic        out_valid_q;
	bsc_pkg::out_t out_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic        div_start;
	logic [31:0] div_dividend;
	logic [31:0] div_divisor;
	logic        div_done;
	logic [31:0] div_quo;

	// Coefficients unpacked from the calibration words.
	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	always_comb begin
		ac1 = bsc_pkg::sx16(calib_a_q[15:0]);
		ac2 = bsc_pkg::sx16(calib_a_q[31:16]);
		ac3 = bsc_pkg::sx16(calib_a_q[47:32]);
		ac4 = {16'd0, calib_a_q[63:48]};
		ac5 = {16'd0, calib_b_q[15:0]};
		ac6 = {16'd0, calib_b_q[31:16]};
		b1  = bsc_pkg::sx16(calib_b_q[47:32]);
		b2  = bsc_pkg::sx16(calib_b_q[63:48]);
		mc  = bsc_pkg::sx16(calib_c_q[15:0]);
		md  = bsc_pkg::sx16(calib_c_q[31:16]);
	end

	// Intermediate values formed from the product register and other datapath registers.
	logic [31:0] t_x1, t_den, t_den_abs, t_mc_abs, t_x2;
	logic [31:0] p_b6, p_sq, p_x3, p_b3, p_x3b, p_up, p_b7, p_x1s;
	always_comb begin
		t_x1      = bsc_pkg::asr(prod_q, 5'd15);
		t_den     = t_x1 + md;
		t_den_abs = t_den[31] ? (32'd0 - t_den) : t_den;
		t_mc_abs  = (mc[31] ? (32'd0 - mc) : mc) << 11;
		t_x2      = neg_q ? (32'd0 - div_quo) : div_quo;
		p_b6      = last_b5_q - bsc_pkg::B6_OFFSET;
		p_sq      = bsc_pkg::asr(prod_q, 5'd12);
		p_x3      = acc_q + bsc_pkg::asr(prod_q, 5'd11);
		p_b3      = bsc_pkg::asr((((ac1 << 2) + p_x3) << oss_q) + 32'd2, 5'd2);
		p_x3b     = bsc_pkg::asr(acc_q + bsc_pkg::asr(prod_q, 5'd16) + 32'd2, 5'd2);
		p_up      = {8'd0, raw_q} >> (4'd8 - {2'd0, oss_q});
		p_b7      = prod_q;
		p_x1s     = bsc_pkg::asr(pv_q, 5'd8);
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_T0: begin
				mul_a = {16'd0, raw_q[15:0]} - ac6;
				mul_b = ac5;
			end
			S_P0: begin
				mul_a = p_b6;
				mul_b = p_b6;
			end
			S_P1: begin
				mul_a = b2;
				mul_b = p_sq;
			end
			S_P2: begin
				mul_a = ac2;
				mul_b = b6_q;
			end
			S_P3: begin
				mul_a = ac3;
				mul_b = b6_q;
			end
			S_P4: begin
				mul_a = b1;
				mul_b = sq_q;
			end
			S_P5: begin
				mul_a = ac4;
				mul_b = p_x3b + bsc_pkg::B4_OFFSET;
			end
			S_P6: begin
				mul_a = p_up - b3_q;
				mul_b = bsc_pkg::scale_of(oss_q);
			end
			S_P8: begin
				mul_a = p_x1s;
				mul_b = p_x1s;
			end
			S_P9: begin
				mul_a = prod_q;
				mul_b = bsc_pkg::P_COEF_A;
			end
			S_P10: begin
				mul_a = pv_q;
				mul_b = bsc_pkg::P_COEF_B;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Shared multiplier, low 32 bits registered.
	always_ff @(posedge clk) begin
		prod_q <= 32'(mul_a * mul_b);
	end

	// Divider requests from the temperature and pressure paths.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = t_mc_abs;
		div_divisor  = t_den_abs;
		if (state_q == S_T1) begin
			div_start = (t_den != 32'd0);
		end else if (state_q == S_P7) begin
			div_start    = (b4_q != 32'd0);
			div_dividend = p_b7[31] ? p_b7 : (p_b7 << 1);
			div_divisor  = b4_q;
		end
	end

	bsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_a_q <= '0;
			calib_b_q <= '0;
			calib_c_q <= '0;
			oss_q     <= bsc_pkg::OSS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bsc_pkg::REG_CALIB_A: calib_a_q <= cfg_data;
				bsc_pkg::REG_CALIB_B: calib_b_q <= cfg_data;
				bsc_pkg::REG_CALIB_C: calib_c_q <= cfg_data[31:0];
				bsc_pkg::REG_OSS:     oss_q     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Sequencer with the control state and the kept b5.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_b5_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The result flag is set when a result is loaded and cleared when it is taken.
			if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (in_data.cmd == bsc_pkg::CMD_PRESS) ? S_P0 : S_T0;
					end
				end
				S_T0: state_q <= S_T1;
				S_T1: begin
					if (t_den == 32'd0) begin
						last_b5_q <= t_x1;
						state_q   <= S_OUT;
					end else begin
						state_q <= S_TDIV;
					end
				end
				S_TDIV: begin
					if (div_done) begin
						state_q <= S_TF;
					end
				end
				S_TF: begin
					last_b5_q <= acc_q + t_x2;
					state_q   <= S_TR;
				end
				S_TR: state_q <= S_OUT;
				S_P0: state_q <= S_P1;
				S_P1: state_q <= S_P2;
				S_P2: state_q <= S_P3;
				S_P3: state_q <= S_P4;
				S_P4: state_q <= S_P5;
				S_P5: state_q <= S_P6;
				S_P6: state_q <= S_P7;
				S_P7: state_q <= (b4_q == 32'd0) ? S_OUT : S_PDIV;
				S_PDIV: begin
					if (div_done) begin
						state_q <= S_P8;
					end
				end
				S_P8:  state_q <= S_P9;
				S_P9:  state_q <= S_P10;
				S_P10: state_q <= S_P11;
				S_P11: state_q <= S_OUT;
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers stepped by the sequencer.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q   <= in_data.cmd;
				raw_q   <= in_data.raw_sample;
				fault_q <= 1'b0;
				res_q   <= '0;
			end
			S_T1: begin
				acc_q <= t_x1;
				neg_q <= mc[31] ^ t_den[31];
				if (t_den == 32'd0) begin
					fault_q <= 1'b1;
					res_q   <= '0;
				end
			end
			S_TR: res_q <= bsc_pkg::asr(last_b5_q + 32'd8, 5'd4);
			S_P0: b6_q <= p_b6;
			S_P1: sq_q <= p_sq;
			S_P2: acc_q <= bsc_pkg::asr(prod_q, 5'd11);
			S_P3: b3_q <= p_b3;
			S_P4: acc_q <= bsc_pkg::asr(prod_q, 5'd13);
			S_P6: b4_q <= prod_q >> 15;
			S_P7: begin
				shl_q <= p_b7[31];
				if (b4_q == 32'd0) begin
					fault_q <= 1'b1;
					res_q   <= '0;
				end
			end
			S_PDIV: begin
				if (div_done) begin
					pv_q <= shl_q ? (div_quo << 1) : div_quo;
				end
			end
			S_P10: acc_q <= bsc_pkg::asr(prod_q, 5'd16);
			S_P11: begin
				res_q <= pv_q + bsc_pkg::asr(acc_q + bsc_pkg::asr(prod_q, 5'd16)
					+ bsc_pkg::P_COEF_C, 5'd4);
			end
			default: ;
		endcase
	end

	// Output register, loaded when the slot is free.
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			out_q.result_kind  <= cmd_q;
			out_q.result_value <= $signed(res_q);
			out_q.divide_fault <= fault_q;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

endmodule

[src/bsc_div.sv]
// Radix-2 restoring divider for 32-bit unsigned operands, one quotient bit per cycle.
module bsc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dsr_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] rem_sh;
	logic [32:0] rem_sub;

	// Shift in the next dividend bit and trial-subtract the divisor.
	always_comb begin
		rem_sh  = {rem_q[31:0], quo_q[31]};
		rem_sub = rem_sh - {1'b0, dsr_q};
	end

	// Control: count 32 steps, pulse done after the last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!rem_sub[32]) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[src/bsc_checker.sv]
// Port-level checker for the compensation core, bound to the top level.
`include "assert_macros.svh"

module bsc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input bsc_pkg::out_t out_data
);

	// A held result keeps its word until taken.
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

	// An accepted reading closes the input until the core finishes it.
	`ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input open during work")

	// A new result only appears at the end of a reading's work.
	`ASSERT_SAME(a_result_after_work, $rose(out_valid), $past(!in_ready), "result without work")

endmodule

bind baro_sensor_compensation_core bsc_checker u_bsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

[test/tb_baro_sensor_compensation_core.sv]
// Testbench for the barometric sensor compensation core, checked against a predictor.
`timescale 1ns / 1ps

module tb_baro_sensor_compensation_core;

	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	bsc_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	bsc_pkg::out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	baro_sensor_compensation_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Predictor copy of the calibration registers and the kept b5.
	logic [63:0] coef_a, coef_b;
	logic [31:0] coef_c, held_b5;
	logic [1:0] oss_sel;

	bsc_pkg::in_t pending_readings[$];
	bsc_pkg::out_t expected_results[$];
	int error_count = 0;
	int checked_count = 0;
	int temp_count = 0, press_count = 0, fault_count = 0;
	bit quiet = 1'b0;
	bit drv_done = 1'b0;
	int drv_gap = 0, mon_gap = 0;
	int idle_cycles = 0;

	function automatic logic [31:0] ext16(logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sra(logic [31:0] v, int s);
		return $signed(v) >>> s;
	endfunction

	// Works out the compensated word for one reading and updates the kept b5.
	function automatic bsc_pkg::out_t compensate(bsc_pkg::in_t rd);
		bsc_pkg::out_t r;
		logic [31:0] ut, x1, x2, x3, den, b6, sq, b3, b4, b7, p, up;
		logic signed [63:0] q;
		r.result_kind = rd.cmd;
		r.divide_fault = 1'b0;
		r.result_value = '0;
		if (rd.cmd == bsc_pkg::CMD_TEMP) begin
			ut = {16'd0, rd.raw_sample[15:0]};
			x1 = sra((ut - {16'd0, coef_b[31:16]}) * {16'd0, coef_b[15:0]}, 15);
			den = x1 + ext16(coef_c[31:16]);
			x2 = '0;
			if (den == 0) begin
				r.divide_fault = 1'b1;
			end else begin
				q = (64'($signed(ext16(coef_c[15:0]))) * 2048) / 64'($signed(den));
				x2 = q[31:0];
			end
			held_b5 = x1 + x2;
			if (!r.divide_fault) r.result_value = sra(held_b5 + 32'd8, 4);
		end else begin
			up = {8'd0, rd.raw_sample} >> (8 - oss_sel);
			b6 = held_b5 - 32'd4000;
			sq = sra(b6 * b6, 12);
			x1 = sra(ext16(coef_b[63:48]) * sq, 11);
			x2 = sra(ext16(coef_a[31:16]) * b6, 11);
			x3 = x1 + x2;
			b3 = sra(((ext16(coef_a[15:0]) * 4 + x3) << oss_sel) + 32'd2, 2);
			x1 = sra(ext16(coef_a[47:32]) * b6, 13);
			x2 = sra(ext16(coef_b[47:32]) * sq, 16);
			x3 = sra(x1 + x2 + 32'd2, 2);
			b4 = ({16'd0, coef_a[63:48]} * (x3 + 32'd32768)) >> 15;
			b7 = (up - b3) * (32'd50000 >> oss_sel);
			if (b4 == 0) begin
				r.divide_fault = 1'b1;
			end else begin
				p = (b7 < 32'h8000_0000) ? ((b7 << 1) / b4) : ((b7 / b4) << 1);
				x1 = sra(p, 8);
				x1 = x1 * x1;
				x1 = sra(x1 * 32'd3038, 16);
				x2 = sra(p * 32'hFFFF_E343, 16);
				p = p + sra(x1 + x2 + 32'd3791, 4);
				r.result_value = p;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		error_count++;
	endtask

	// Driver: presents queued readings, with random bursts of idling.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_results.push_back(compensate(in_data));
			end
			if (!(in_valid && !in_ready)) begin
				if (drv_gap > 0) begin
					drv_gap <= drv_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_readings.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= pending_readings.pop_front();
					if (!quiet && $urandom_range(0, 5) == 0) drv_gap <= $urandom_range(1, 5);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: takes result words with random stalls and checks each field.
	always @(posedge clk) begin
		bsc_pkg::out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("unexpected result word at %0t", $time);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					checked_count++;
					if (out_data.result_kind != want.result_kind)
						report_mismatch("kind", 32'(out_data.result_kind),
							32'(want.result_kind));
					if (out_data.result_value != want.result_value)
						report_mismatch("value", out_data.result_value, want.result_value);
					if (out_data.divide_fault != want.divide_fault)
						report_mismatch("fault", 32'(out_data.divide_fault),
							32'(want.divide_fault));
					if (want.result_kind == bsc_pkg::CMD_TEMP) temp_count++;
					else press_count++;
					if (want.divide_fault) fault_count++;
				end
			end
			if (mon_gap > 0) begin
				mon_gap <= mon_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 4) == 0) mon_gap <= $urandom_range(1, 5);
			end
		end
	end

	// Watchdog on cycles with no accepted word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("FAILURE");
					$finish;
				end
			end
		end
	end

	// Waits until the driver is empty and every expected word has come.
	task automatic drain();
		do @(posedge clk);
		while (pending_readings.size() > 0 || in_valid || expected_results.size() > 0);
		repeat (60) @(posedge clk);
	endtask

	// One register write; the channel is then left idle before the task returns.
	task automatic write_reg(logic [1:0] idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			bsc_pkg::REG_CALIB_A: coef_a = val;
			bsc_pkg::REG_CALIB_B: coef_b = val;
			bsc_pkg::REG_CALIB_C: coef_c = val[31:0];
			default: oss_sel = val[1:0];
		endcase
		@(posedge clk);
	endtask

	function automatic bsc_pkg::in_t reading(logic kind, logic [23:0] raw);
		bsc_pkg::in_t r;
		r.cmd = kind;
		r.raw_sample = raw;
		return r;
	endfunction

	// Typical factory coefficients with a random spread around them.
	task automatic realistic_calib();
		logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		ac1 = 16'(408 + $urandom_range(0, 8000));
		ac2 = 16'(-72 - int'($urandom_range(0, 1000)));
		ac3 = 16'(-14383 + int'($urandom_range(0, 4000)));
		ac4 = 16'(32741 + $urandom_range(0, 2000));
		ac5 = 16'(32757 - $urandom_range(0, 8000));
		ac6 = 16'(23153 + $urandom_range(0, 4000));
		b1 = 16'(6190 + $urandom_range(0, 500));
		b2 = 16'($urandom_range(0, 100));
		mc = 16'(-8711 - int'($urandom_range(0, 2000)));
		md = 16'(2868 + $urandom_range(0, 1000));
		write_reg(bsc_pkg::REG_CALIB_A, {ac4, ac3, ac2, ac1});
		write_reg(bsc_pkg::REG_CALIB_B, {b2, b1, ac6, ac5});
		write_reg(bsc_pkg::REG_CALIB_C, {32'd0, md, mc});
	endtask

	initial begin
		int phase;
		coef_a = '0; coef_b = '0; coef_c = '0; held_b5 = '0; oss_sel = bsc_pkg::OSS_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pressure before any temperature, with all-zero coefficients: zero divisor.
		pending_readings.push_back(reading(bsc_pkg::CMD_PRESS, 24'hFFFFFF));
		pending_readings.push_back(reading(bsc_pkg::CMD_TEMP, 24'h000000));
		pending_readings.push_back(reading(bsc_pkg::CMD_PRESS, 24'h000000));
		drain();

		// Zero temperature divisor: ac5 = 0 makes x1 zero, md = 0.
		write_reg(bsc_pkg::REG_CALIB_C, 64'h0000_1234);
		pending_readings.push_back(reading(bsc_pkg::CMD_TEMP, 24'hAB1234));
		drain();

		// Realistic calibration with field extremes at each oversampling.
		realistic_calib();
		for (int o = 0; o < 4; o++) begin
			write_reg(bsc_pkg::REG_OSS, 64'(o));
			pending_readings.push_back(reading(bsc_pkg::CMD_TEMP, 24'hFF6C51));
			pending_readings.push_back(reading(bsc_pkg::CMD_PRESS, 24'h5D23FF));
			pending_readings.push_back(reading(bsc_pkg::CMD_PRESS, 24'h000000));
			pending_readings.push_back(reading(bsc_pkg::CMD_TEMP, 24'h00FFFF));
			pending_readings.push_back(reading(bsc_pkg::CMD_PRESS, 24'hFFFFFF));
			drain();
		end

		// Extreme coefficient words.
		write_reg(bsc_pkg::REG_CALIB_A, '1);
		write_reg(bsc_pkg::REG_CALIB_B, '1);
		write_reg(bsc_pkg::REG_CALIB_C, 64'hFFFF_FFFF);
		pending_readings.push_back(reading(bsc_pkg::CMD_TEMP, 24'h7FFF00));
		pending_readings.push_back(reading(bsc_pkg::CMD_PRESS, 24'h800000));
		drain();

		// Random phases: mostly realistic calibrations, some raw noise words.
		for (phase = 0; phase < 28; phase++) begin
			if (phase % 4 == 3) begin
				write_reg(bsc_pkg::REG_CALIB_A, {$urandom, $urandom});
				write_reg(bsc_pkg::REG_CALIB_B, {$urandom, $urandom});
				write_reg(bsc_pkg::REG_CALIB_C, 64'($urandom));
			end else begin
				realistic_calib();
			end
			write_reg(bsc_pkg::REG_OSS, 64'($urandom_range(0, 3)));
			if (phase >= 24) quiet = 1'b1;
			for (int n = 0; n < 48; n++) begin
				if ($urandom_range(0, 3) == 0)
					pending_readings.push_back(reading(bsc_pkg::CMD_TEMP,
						24'($urandom_range(20000, 40000)) | (24'($urandom) & 24'hFF0000)));
				else if ($urandom_range(0, 9) == 0)
					pending_readings.push_back(reading(1'($urandom), 24'($urandom)));
				else
					pending_readings.push_back(reading(bsc_pkg::CMD_PRESS,
						24'($urandom_range(20000, 45000)) << 8 | 24'($urandom_range(0, 255))));
			end
			drain();
		end

		$display("Checked %0d words: %0d temperature, %0d pressure, %0d divide faults,",
			checked_count, temp_count, press_count, fault_count);
		$display("across all oversampling settings and extreme and typical calibrations.");
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

[baro_sensor_compensation_core.f]
+incdir+src
src/bsc_pkg.sv
src/bsc_div.sv
src/baro_sensor_compensation_core.sv
src/bsc_checker.sv
test/tb_baro_sensor_compensation_core.sv
